// File: hw/rtl/car_pkg.sv
// shared types, constants and line-length functions of the comb/allpass reverb
`timescale 1ns / 1ps
package car_pkg;

  localparam int LI_W = 4;

  localparam logic [2:0] MS_S_CIG = 3'd0;
  localparam logic [2:0] MS_O_FB  = 3'd1;
  localparam logic [2:0] MS_SUM   = 3'd2;
  localparam logic [2:0] MS_S_DRY = 3'd3;
  localparam logic [2:0] MS_X_WET = 3'd4;

  localparam int unsigned COMB_MS [8] = '{50, 56, 61, 68, 72, 78, 84, 90};
  localparam int unsigned AP_MS [2] = '{10, 25};

  localparam int unsigned CIG_RESET = 32768;
  localparam int unsigned DRY_RESET = 45875;
  localparam int unsigned WET_RESET = 13763;
  localparam int unsigned TENTH_Q16 = 6554;

  function automatic int unsigned line_len(input int unsigned ms, input int unsigned rate);
    int unsigned n;
    n = ms * rate / 1000;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic int unsigned comb_base(input int unsigned n, input int unsigned rate);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < n && k < 8; k++) begin
      acc = acc + line_len(COMB_MS[k], rate);
    end
    return acc;
  endfunction

  function automatic int unsigned ap_base(input int unsigned n, input int unsigned rate);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < n && k < 2; k++) begin
      acc = acc + line_len(AP_MS[k], rate);
    end
    return acc;
  endfunction

  typedef struct packed {
    logic            clr;
    logic            accept;
    logic            mul_en;
    logic [2:0]      mul_sel;
    logic            gs_ld;
    logic            o_ld;
    logic            sum_add;
    logic            cw;
    logic            x_ld;
    logic            ap_do;
    logic            acc_ld;
    logic            y_ld;
    logic            out_ld;
    logic [LI_W-1:0] li;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
  } stat_t;

endpackage

// File: hw/rtl/car_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module car_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/car_ctrl.sv
// sequencer state machine of the reverb
`timescale 1ns / 1ps
module car_ctrl #(
  parameter int COMB_LINES    = 8,
  parameter int ALLPASS_LINES = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output car_pkg::cmd_t       cmd,
  input  car_pkg::stat_t      stat
);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_MG    = 4'd2;
  localparam logic [3:0] ST_GS    = 4'd3;
  localparam logic [3:0] ST_CR    = 4'd4;
  localparam logic [3:0] ST_CO    = 4'd5;
  localparam logic [3:0] ST_CM    = 4'd6;
  localparam logic [3:0] ST_CW    = 4'd7;
  localparam logic [3:0] ST_XM    = 4'd8;
  localparam logic [3:0] ST_XS    = 4'd9;
  localparam logic [3:0] ST_AR    = 4'd10;
  localparam logic [3:0] ST_AO    = 4'd11;
  localparam logic [3:0] ST_DM    = 4'd12;
  localparam logic [3:0] ST_DW    = 4'd13;
  localparam logic [3:0] ST_DF    = 4'd14;
  localparam logic [3:0] ST_OUT   = 4'd15;

  localparam logic [car_pkg::LI_W-1:0] LAST_COMB = car_pkg::LI_W'(COMB_LINES - 1);
  localparam logic [car_pkg::LI_W-1:0] FIRST_AP  = car_pkg::LI_W'(COMB_LINES);
  localparam logic [car_pkg::LI_W-1:0] LAST_AP   =
    car_pkg::LI_W'(COMB_LINES + ALLPASS_LINES - 1);

  logic [3:0]                state_r, state_nxt;
  logic [car_pkg::LI_W-1:0]  li_r, li_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    li_nxt        = li_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.li        = li_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_MG;
        end
      end
      ST_MG: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = car_pkg::MS_S_CIG;
        state_nxt   = ST_GS;
      end
      ST_GS: begin
        cmd.gs_ld = 1'b1;
        li_nxt    = '0;
        state_nxt = ST_CR;
      end
      ST_CR: begin
        state_nxt = ST_CO;
      end
      ST_CO: begin
        cmd.o_ld  = 1'b1;
        state_nxt = ST_CM;
      end
      ST_CM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = car_pkg::MS_O_FB;
        cmd.sum_add = 1'b1;
        state_nxt   = ST_CW;
      end
      ST_CW: begin
        cmd.cw = 1'b1;
        if (li_r == LAST_COMB) begin
          state_nxt = ST_XM;
        end else begin
          li_nxt    = li_r + 1'b1;
          state_nxt = ST_CR;
        end
      end
      ST_XM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = car_pkg::MS_SUM;
        state_nxt   = ST_XS;
      end
      ST_XS: begin
        cmd.x_ld  = 1'b1;
        li_nxt    = FIRST_AP;
        state_nxt = ST_AR;
      end
      ST_AR: begin
        state_nxt = ST_AO;
      end
      ST_AO: begin
        cmd.ap_do = 1'b1;
        if (li_r == LAST_AP) begin
          state_nxt = ST_DM;
        end else begin
          li_nxt    = li_r + 1'b1;
          state_nxt = ST_AR;
        end
      end
      ST_DM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = car_pkg::MS_S_DRY;
        state_nxt   = ST_DW;
      end
      ST_DW: begin
        cmd.acc_ld  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = car_pkg::MS_X_WET;
        state_nxt   = ST_DF;
      end
      ST_DF: begin
        cmd.y_ld  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      li_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      li_r        <= li_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/car_dpath.sv
// datapath: gain registers, delay memories, line positions and shared multiplier
`timescale 1ns / 1ps
module car_dpath #(
  parameter int SAMPLE_RATE     = 48000,
  parameter int COMB_LINES      = 8,
  parameter int ALLPASS_LINES   = 2,
  parameter int DELAY_WORD_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  car_pkg::cmd_t       cmd,
  output car_pkg::stat_t      stat,
  input  logic signed [15:0]  in_sample_in,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output logic signed [15:0]  out_sample_out
);

  localparam int DW    = DELAY_WORD_BITS;
  localparam int NL    = COMB_LINES + ALLPASS_LINES;
  localparam int LIX_W = (NL > 1) ? $clog2(NL) : 1;
  localparam int C_DEPTH = car_pkg::comb_base(COMB_LINES, SAMPLE_RATE) + 1;
  localparam int A_DEPTH = car_pkg::ap_base(ALLPASS_LINES, SAMPLE_RATE) + 1;
  localparam int CA_W  = $clog2(C_DEPTH);
  localparam int AA_W  = $clog2(A_DEPTH);
  localparam int AD_W  = (CA_W > AA_W) ? CA_W : AA_W;
  localparam int MAX_LEN = car_pkg::line_len(90, SAMPLE_RATE);
  localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AW    = DW + 4;
  localparam int PW    = AW + 18;
  localparam int SW    = PW + 1;

  localparam logic [CA_W-1:0] CLR_LAST = CA_W'(C_DEPTH - 1);
  localparam logic [CA_W-1:0] AP_END   = CA_W'(A_DEPTH);

  localparam logic [2:0] R_FB_LOW  = 3'd0;
  localparam logic [2:0] R_FB_HIGH = 3'd1;
  localparam logic [2:0] R_CIG     = 3'd2;
  localparam logic [2:0] R_DRY     = 3'd3;
  localparam logic [2:0] R_WET     = 3'd4;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    logic [SW-DW:0] top;
    top = v[SW-1:DW-1];
    if ((&top) || !(|top)) begin
      return v[DW-1:0];
    end
    return v[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
    logic [SW-16:0] top;
    top = v[SW-1:15];
    if ((&top) || !(|top)) begin
      return v[15:0];
    end
    return v[SW-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  // configuration registers
  logic [63:0] fb_low_r, fb_high_r;
  logic [16:0] cig_r, dry_r, wet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_low_r  <= '0;
      fb_high_r <= '0;
      cig_r     <= 17'(car_pkg::CIG_RESET);
      dry_r     <= 17'(car_pkg::DRY_RESET);
      wet_r     <= 17'(car_pkg::WET_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        R_FB_LOW:  fb_low_r  <= cfg_wdata;
        R_FB_HIGH: fb_high_r <= cfg_wdata;
        R_CIG:     cig_r     <= cfg_wdata[16:0];
        R_DRY:     dry_r     <= cfg_wdata[16:0];
        R_WET:     wet_r     <= cfg_wdata[16:0];
        default: begin
        end
      endcase
    end
  end

  // line positions and addresses
  logic [LIX_W-1:0] li;
  logic [AD_W-1:0]  base_w [NL];
  logic [POS_W-1:0] last_w [NL];
  logic [POS_W-1:0] pos_r  [NL];
  logic             adv;
  logic [AD_W-1:0]  addr;

  assign li  = cmd.li[LIX_W-1:0];
  assign adv = cmd.cw || cmd.ap_do;

  for (genvar g = 0; g < NL; g++) begin : g_line
    if (g < COMB_LINES) begin : g_comb
      assign base_w[g] = AD_W'(car_pkg::comb_base(g, SAMPLE_RATE));
      assign last_w[g] = POS_W'(car_pkg::line_len(car_pkg::COMB_MS[g], SAMPLE_RATE) - 1);
    end else begin : g_ap
      assign base_w[g] = AD_W'(car_pkg::ap_base(g - COMB_LINES, SAMPLE_RATE));
      assign last_w[g] =
        POS_W'(car_pkg::line_len(car_pkg::AP_MS[g - COMB_LINES], SAMPLE_RATE) - 1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pos_r[g] <= '0;
      end else if (adv && li == LIX_W'(g)) begin
        pos_r[g] <= (pos_r[g] == last_w[g]) ? '0 : pos_r[g] + 1'b1;
      end
    end
  end

  assign addr = base_w[li] + AD_W'(pos_r[li]);

  // clearing counter
  logic [CA_W-1:0] clr_cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end
  assign stat.clr_done = (clr_cnt_r == CLR_LAST);

  // multiplier
  logic signed [15:0]   s_r;
  logic signed [17:0]   gs_r;
  logic signed [DW-1:0] o_r, x_r;
  logic signed [DW+2:0] sum_r;
  logic signed [AW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [PW-1:0] prod_r, acc_r, rnd;
  logic [15:0]          fb;
  logic [63:0]          fb_word;

  assign fb_word = cmd.li[2] ? fb_high_r : fb_low_r;
  assign fb      = fb_word[16*cmd.li[1:0] +: 16];

  always_comb begin
    unique case (cmd.mul_sel)
      car_pkg::MS_S_CIG: begin
        mul_a = AW'(s_r);
        mul_b = {1'b0, cig_r};
      end
      car_pkg::MS_O_FB: begin
        mul_a = AW'(o_r);
        mul_b = {2'b0, fb};
      end
      car_pkg::MS_SUM: begin
        mul_a = AW'(sum_r);
        mul_b = 18'(car_pkg::TENTH_Q16);
      end
      car_pkg::MS_S_DRY: begin
        mul_a = AW'(s_r);
        mul_b = {1'b0, dry_r};
      end
      car_pkg::MS_X_WET: begin
        mul_a = AW'(x_r);
        mul_b = {1'b0, wet_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd = (prod_r + PW'(32768)) >>> 16;

  // delay memories
  logic [DW-1:0]  c_rdata, a_rdata;
  logic           c_we, a_we;
  logic [CA_W-1:0] c_waddr;
  logic [AA_W-1:0] a_waddr;
  logic [DW-1:0]  c_wdata, a_wdata;
  logic signed [DW-1:0] b, ap_o;
  logic signed [SW-1:0] y_full;
  logic signed [15:0]   y_r, out_r;

  assign b    = $signed(a_rdata);
  assign ap_o = sat_dw(SW'(b) - SW'(x_r));

  assign c_we    = cmd.clr || cmd.cw;
  assign c_waddr = cmd.clr ? clr_cnt_r : addr[CA_W-1:0];
  assign c_wdata = cmd.clr ? '0 : sat_dw(SW'(s_r) + SW'($signed(rnd[DW:0])));

  assign a_we    = (cmd.clr && clr_cnt_r < AP_END) || cmd.ap_do;
  assign a_waddr = cmd.clr ? clr_cnt_r[AA_W-1:0] : addr[AA_W-1:0];
  assign a_wdata = cmd.clr ? '0 : sat_dw(SW'(x_r) + SW'((SW'(b) + SW'(1)) >>> 1));

  assign y_full = (SW'(acc_r) + SW'(prod_r) + SW'(32768)) >>> 16;

  car_ram #(.WIDTH(DW), .DEPTH(C_DEPTH)) u_comb_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (addr[CA_W-1:0]),
    .rdata (c_rdata)
  );

  car_ram #(.WIDTH(DW), .DEPTH(A_DEPTH)) u_ap_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (addr[AA_W-1:0]),
    .rdata (a_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r   <= in_sample_in;
      sum_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + (DW+3)'(o_r);
    end
    if (cmd.mul_en) begin
      prod_r <= PW'(mul_a * mul_b);
    end
    if (cmd.gs_ld) begin
      gs_r <= rnd[17:0];
    end
    if (cmd.o_ld) begin
      o_r <= sat_dw(SW'($signed(c_rdata)) + SW'(gs_r));
    end
    if (cmd.x_ld) begin
      x_r <= sat_dw(SW'($signed(rnd[DW+2:0])));
    end else if (cmd.ap_do) begin
      x_r <= ap_o;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.y_ld) begin
      y_r <= sat16(y_full);
    end
    if (cmd.out_ld) begin
      out_r <= y_r;
    end
  end

  assign out_sample_out = out_r;

endmodule

// File: hw/rtl/comb_allpass_reverb_top.sv
// Schroeder-style comb/allpass reverb, top level
// Input channel in_valid/in_stall/in_sample_in takes one signed Q1.15 sample per request;
// output channel out_valid/out_stall/out_sample_out gives one mixed Q1.15 sample for each.
// Gains are to be written through cfg_we/cfg_index/cfg_wdata while the block is idle;
// the block itself does not enforce this. Each comb line needs a read, an add, a multiply
// and a write-back on the comb memory and the one shared multiplier, each allpass line a
// read and a write-back, one line after another for each sample.
// The finished sample sits in an output register, so the next input is taken while it
// waits; a stalled receiver holds the block only when a second result is ready.
// After reset the comb and allpass memories are cleared one word per cycle with in_stall
// high until the last comb memory word is written. Config writes are taken during this
// pass. Line positions restart at zero.
`timescale 1ns / 1ps
module comb_allpass_reverb_top #(
  parameter int SAMPLE_RATE     = 48000,
  parameter int COMB_LINES      = 8,
  parameter int ALLPASS_LINES   = 2,
  parameter int DELAY_WORD_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_wdata
);

  car_pkg::cmd_t  cmd;
  car_pkg::stat_t stat;

  car_ctrl #(
    .COMB_LINES    (COMB_LINES),
    .ALLPASS_LINES (ALLPASS_LINES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  car_dpath #(
    .SAMPLE_RATE     (SAMPLE_RATE),
    .COMB_LINES      (COMB_LINES),
    .ALLPASS_LINES   (ALLPASS_LINES),
    .DELAY_WORD_BITS (DELAY_WORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_sample_in   (in_sample_in),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_sample_out (out_sample_out)
  );

`ifndef SYNTH
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken right after reset");
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in work");
  a_no_ram_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall) |-> !(cmd.cw || cmd.ap_do || cmd.clr))
    else $error("delay memory written while idle");
`endif

endmodule
